[rtl/set_assoc_lru_cache_lookup_top_macros.svh]
// Assertion macros used by the cache lookup top module.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SALC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/salc_pkg.sv]
// Package: shared constants, types and helpers for the cache lookup.
`default_nettype none
package salc_pkg;

  // Default structure sizes
  localparam int WAYS_DEF      = 8;
  localparam int SETS_DEF      = 256;
  localparam int ADDR_BITS_DEF = 32;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;
  localparam int WAY_OUT_W = 3;
  localparam int WAY_IDX_W = 4;

  // Limits on the address split
  localparam logic [CFG_W-1:0] OFF_MAX   = 4'd12;
  localparam int               IDX_LIMIT = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd8;
  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [CFG_W-1:0] nways;
    logic [CFG_W-1:0] off;
    logic [CFG_W-1:0] idx;
  } cfg_eff_t;

  // Outcome of one set lookup
  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [WAY_IDX_W-1:0] used_way;
  } lookup_t;

  // Largest k with 2^k <= n, capped at IDX_LIMIT
  function automatic int floor_log2(input int n);
    int k;
    k = 0;
    for (int j = 0; j < IDX_LIMIT; j++) begin
      if ((1 << (j + 1)) <= n) begin
        k = j + 1;
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/set_assoc_lru_cache_lookup_top.sv]
// A request is held in the lookup stage registers, then its result in the output register.
// Throughput: one request per cycle while the output is not stalled; the set memory
// is read on acceptance and written back when the lookup stage fires, with the last
// written row forwarded to a following request to the same set.
// Reset: a clearing pass writes all SETS rows, one per cycle (256 by default),
// during which no request is taken; configuration writes are taken throughout.
`default_nettype none
module set_assoc_lru_cache_lookup_top #(
  parameter int WAYS      = salc_pkg::WAYS_DEF,
  parameter int SETS      = salc_pkg::SETS_DEF,
  parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [salc_pkg::ADDR_W-1:0]       address,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   hit,
  output logic      [salc_pkg::WAY_OUT_W-1:0]    way,
  output logic                                   replaced_valid
);

  `include "set_assoc_lru_cache_lookup_top_macros.svh"

  localparam int TAG_W  = (ADDR_BITS < salc_pkg::ADDR_W) ? ADDR_BITS : salc_pkg::ADDR_W;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W  = WAYS * (1 + TAG_W + RANK_W);
  localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= salc_pkg::ADDR_W) ? '1 :
    salc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [SET_W-1:0]                 clr_cnt;
  logic                             clr_last;
  salc_pkg::cfg_eff_t               eff;
  logic [salc_pkg::ADDR_W-1:0]      addr_m;
  logic [salc_pkg::CFG_W:0]         shamt;
  logic [salc_pkg::ADDR_W-1:0]      set_full;
  logic [salc_pkg::ADDR_W-1:0]      tag_full;
  logic [SET_W-1:0]                 set_in;
  logic [TAG_W-1:0]                 tag_in;
  logic                             in_accept;
  logic                             out_free;
  logic                             s1_valid;
  logic                             s1_fire;
  logic [SET_W-1:0]                 s1_set;
  logic [TAG_W-1:0]                 s1_tag;
  logic                             ram_we;
  logic [SET_W-1:0]                 ram_waddr;
  logic [ROW_W-1:0]                 ram_wdata;
  logic [SET_W-1:0]                 ram_raddr;
  logic [ROW_W-1:0]                 ram_rdata;
  logic                             wr_q;
  logic [SET_W-1:0]                 wr_set;
  logic [ROW_W-1:0]                 wr_row;
  logic [ROW_W-1:0]                 row_cur;
  logic [ROW_W-1:0]                 row_new;
  salc_pkg::lookup_t                res;

  salc_cfg #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff)
  );

  // Split the address into set index and tag
  always_comb begin
    addr_m   = address & ADDR_MASK;
    shamt    = {1'b0, eff.off} + {1'b0, eff.idx};
    set_full = (addr_m >> eff.off) & ~({salc_pkg::ADDR_W{1'b1}} << eff.idx);
    tag_full = addr_m >> shamt;
    set_in   = set_full[SET_W-1:0];
    tag_in   = tag_full[TAG_W-1:0];
  end

  // Handshakes
  assign out_free  = !out_valid || out_ready;
  assign s1_fire   = s1_valid && out_free;
  assign in_ready  = (state == ST_RUN) && (!s1_valid || out_free);
  assign in_accept = in_valid && in_ready;

  // Clearing pass after reset
  assign clr_last = (clr_cnt == LAST_SET);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) begin
        state_next = ST_RUN;
      end
      ST_RUN: state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
    end
  end

  // Set memory: read on accept, re-read the held set while stalled
  assign ram_raddr = in_accept ? set_in : s1_set;
  assign ram_we    = (state == ST_CLEAR) || s1_fire;
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : s1_set;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : row_new;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Forward the row written at the last edge
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q <= 1'b0;
    end else begin
      wr_q <= ram_we;
    end
    wr_set <= ram_waddr;
    wr_row <= ram_wdata;
  end

  assign row_cur = (wr_q && (wr_set == s1_set)) ? wr_row : ram_rdata;

  // Lookup stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_set <= set_in;
      s1_tag <= tag_in;
    end
  end

  salc_way_logic #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W)
  ) u_way_logic (
    .row_in  (row_cur),
    .tag_in  (s1_tag),
    .nways   (eff.nways),
    .res     (res),
    .row_out (row_new)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      hit            <= res.hit;
      way            <= salc_pkg::WAY_OUT_W'(res.used_way);
      replaced_valid <= res.evicted;
    end
  end

  `SALC_ASSERT_NOW(a_no_accept_in_clear, state == ST_CLEAR, !in_ready,
    "request accepted during clearing pass")
  `SALC_ASSERT_NOW(a_no_lookup_in_clear, state == ST_CLEAR, !s1_valid,
    "lookup stage busy during clearing pass")
  `SALC_ASSERT_NEXT(a_fire_lands, s1_fire, out_valid,
    "fired lookup did not reach the output register")
  `SALC_ASSERT_NOW(a_used_way_active, s1_valid, res.used_way < eff.nways,
    "lookup chose an inactive way")
  `SALC_ASSERT_NEXT(a_clear_ends, (state == ST_CLEAR) && clr_last, state == ST_RUN,
    "clearing pass did not end after the last set")

endmodule
`default_nettype wire

[rtl/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/salc_cfg.sv]
// Configuration registers and their clamped effective values.
`default_nettype none
module salc_cfg #(
  parameter int WAYS = salc_pkg::WAYS_DEF,
  parameter int SETS = salc_pkg::SETS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]      cfg_data,
  output salc_pkg::cfg_eff_t                   eff
);

  localparam logic [salc_pkg::CFG_W:0]   WAYS_V  = (salc_pkg::CFG_W + 1)'(WAYS);
  localparam logic [salc_pkg::CFG_W-1:0] IDX_MAX =
    salc_pkg::CFG_W'(salc_pkg::floor_log2(SETS));

  logic [salc_pkg::CFG_W-1:0] ways_in_use;
  logic [salc_pkg::CFG_W-1:0] offset_bits;
  logic [salc_pkg::CFG_W-1:0] index_bits;

  assign cfg_ready = 1'b1;

  // Capture register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= salc_pkg::WAYS_IN_USE_RST;
      offset_bits <= salc_pkg::OFFSET_BITS_RST;
      index_bits  <= salc_pkg::INDEX_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        salc_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        salc_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data;
        salc_pkg::CFG_INDEX_BITS:  index_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp to the ranges the structure supports
  always_comb begin
    if (ways_in_use == '0) begin
      eff.nways = salc_pkg::CFG_W'(1);
    end else if ({1'b0, ways_in_use} > WAYS_V) begin
      eff.nways = salc_pkg::CFG_W'(WAYS);
    end else begin
      eff.nways = ways_in_use;
    end
    eff.off = (offset_bits > salc_pkg::OFF_MAX) ? salc_pkg::OFF_MAX : offset_bits;
    eff.idx = (index_bits > IDX_MAX) ? IDX_MAX : index_bits;
  end

endmodule
`default_nettype wire

[rtl/salc_way_logic.sv]
// Per-set tag compare, victim choice and recency rank update.
`default_nettype none
module salc_way_logic #(
  parameter int WAYS   = salc_pkg::WAYS_DEF,
  parameter int TAG_W  = salc_pkg::ADDR_BITS_DEF,
  parameter int RANK_W = 3,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int ROW_W = WAYS * (1 + TAG_W + RANK_W)
) (
  input  wire logic [ROW_W-1:0]           row_in,
  input  wire logic [TAG_W-1:0]           tag_in,
  input  wire logic [salc_pkg::CFG_W-1:0] nways,
  output salc_pkg::lookup_t               res,
  output logic      [ROW_W-1:0]           row_out
);

  localparam logic [RANK_W-1:0] RANK_CAP = RANK_W'(WAYS - 1);

  logic [WAYS-1:0]              valid;
  logic [WAYS-1:0][TAG_W-1:0]   tags;
  logic [WAYS-1:0][RANK_W-1:0]  ranks;
  logic [WAYS-1:0]              valid_n;
  logic [WAYS-1:0][TAG_W-1:0]   tags_n;
  logic [WAYS-1:0][RANK_W-1:0]  ranks_n;
  logic [WAYS-1:0]              active;
  logic                         hit;
  logic                         found_free;
  logic [WAY_W-1:0]             hit_way;
  logic [WAY_W-1:0]             free_way;
  logic [WAY_W-1:0]             vic_way;
  logic [RANK_W-1:0]            max_rank;
  logic [WAY_W-1:0]             used;
  logic [RANK_W-1:0]            old_rank;

  assign {valid, tags, ranks} = row_in;

  // Search the active ways for a tag match and a free way
  always_comb begin
    hit        = 1'b0;
    found_free = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      active[i] = (5'(i) < {1'b0, nways});
      if (active[i] && valid[i] && (tags[i] == tag_in)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (active[i] && !valid[i]) begin
        found_free = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
  end

  // Pick the highest rank; ties go to the lowest way
  always_comb begin
    vic_way  = '0;
    max_rank = ranks[0];
    for (int i = 1; i < WAYS; i++) begin
      if (active[i] && (ranks[i] > max_rank)) begin
        max_rank = ranks[i];
        vic_way  = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      used = hit_way;
    end else if (found_free) begin
      used = free_way;
    end else begin
      used = vic_way;
    end
    old_rank = ranks[used];
  end

  // Build the row to write back
  always_comb begin
    valid_n = valid;
    tags_n  = tags;
    if (!hit) begin
      valid_n[used] = 1'b1;
      tags_n[used]  = tag_in;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == used) begin
        ranks_n[i] = '0;
      end else if (active[i] && valid[i] && (!hit || (ranks[i] < old_rank)) &&
                   (ranks[i] < RANK_CAP)) begin
        ranks_n[i] = ranks[i] + RANK_W'(1);
      end else begin
        ranks_n[i] = ranks[i];
      end
    end
  end

  assign row_out      = {valid_n, tags_n, ranks_n};
  assign res.hit      = hit;
  assign res.evicted  = !hit && !found_free;
  assign res.used_way = salc_pkg::WAY_IDX_W'(used);

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the set-associative LRU cache lookup.
`timescale 1ns / 1ps
module tb_top;
  import salc_pkg::*;

  // Register index that the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic                 found;
    logic [WAY_OUT_W-1:0] way_sel;
    logic                 evicted;
  } lookup_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_PERIODIC,
    READY_RANDOM,
    READY_LONG_STALL
  } ready_mode_t;

  // Tracks cache contents and the lookup results still owed by the block
  class lru_lookup_scoreboard;
    logic [CFG_W-1:0] ways_reg;
    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] index_reg;
    int unsigned      index_cap;
    bit               line_valid [SETS_DEF][WAYS_DEF];
    logic [31:0]      line_tag   [SETS_DEF][WAYS_DEF];
    bit [2:0]         line_rank  [SETS_DEF][WAYS_DEF];
    lookup_result_t   expected_q [$];
    int               error_count;

    function new();
      ways_reg    = WAYS_IN_USE_RST;
      offset_reg  = OFFSET_BITS_RST;
      index_reg   = INDEX_BITS_RST;
      error_count = 0;
      index_cap   = 0;
      while (index_cap < 12 && (1 << (index_cap + 1)) <= SETS_DEF) index_cap++;
      foreach (line_valid[r, w]) begin
        line_valid[r][w] = 1'b0;
        line_tag[r][w]   = '0;
        line_rank[r][w]  = '0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WAYS_IN_USE: ways_reg = data;
        CFG_OFFSET_BITS: offset_reg = data;
        CFG_INDEX_BITS: index_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned eff_offset();
      return (offset_reg > OFF_MAX) ? OFF_MAX : offset_reg;
    endfunction

    function int unsigned eff_index();
      return (index_reg > index_cap) ? index_cap : index_reg;
    endfunction

    function int unsigned eff_ways();
      if (ways_reg == 0) return 1;
      return (ways_reg > WAYS_DEF) ? WAYS_DEF : ways_reg;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Look the address up, update tags and ranks, queue the outcome
    function void note_request(logic [ADDR_W-1:0] addr);
      int unsigned off, idx, nw, row, used, old_rank;
      logic [31:0] tag;
      bit was_hit, found_free, evicted;
      lookup_result_t res;
      off = eff_offset();
      idx = eff_index();
      nw  = eff_ways();
      row = (addr >> off) & ((32'd1 << idx) - 1);
      tag = addr >> (off + idx);
      was_hit = 1'b0;
      found_free = 1'b0;
      evicted = 1'b0;
      used = 0;
      // lowest matching active way wins
      for (int i = 0; i < nw; i++) begin
        if (!was_hit && line_valid[row][i] && line_tag[row][i] == tag) begin
          was_hit = 1'b1;
          used = i;
        end
      end
      if (!was_hit) begin
        for (int i = 0; i < nw; i++) begin
          if (!found_free && !line_valid[row][i]) begin
            found_free = 1'b1;
            used = i;
          end
        end
        // victim: highest rank, lowest way on a tie
        if (!found_free) begin
          used = 0;
          for (int i = 1; i < nw; i++) begin
            if (line_rank[row][i] > line_rank[row][used]) used = i;
          end
          evicted = 1'b1;
        end
        line_valid[row][used] = 1'b1;
        line_tag[row][used] = tag;
      end
      // age the other valid active ways, saturating at the top rank
      old_rank = line_rank[row][used];
      for (int i = 0; i < nw; i++) begin
        if (i != used && line_valid[row][i] && (!was_hit || line_rank[row][i] < old_rank)
            && line_rank[row][i] < WAYS_DEF - 1) begin
          line_rank[row][i]++;
        end
      end
      line_rank[row][used] = '0;
      res.found   = was_hit;
      res.way_sel = used[WAY_OUT_W-1:0];
      res.evicted = evicted;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        error_count++;
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      end
    endfunction

    function void check_result(logic act_hit, logic [WAY_OUT_W-1:0] act_way, logic act_evict);
      lookup_result_t res;
      if (expected_q.size() == 0) begin
        error_count++;
        $error("result with no request pending: hit=%0d way=%0d replaced_valid=%0d",
               act_hit, act_way, act_evict);
        return;
      end
      res = expected_q.pop_front();
      compare_field("hit", 32'(res.found), 32'(act_hit));
      compare_field("way", 32'(res.way_sel), 32'(act_way));
      compare_field("replaced_valid", 32'(res.evicted), 32'(act_evict));
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic                 replaced_valid;

  lru_lookup_scoreboard sb = new();

  set_assoc_lru_cache_lookup_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way            (way),
    .replaced_valid (replaced_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver backpressure: switch to a randomly chosen ready pattern and period
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned ready_count = 0;
  int unsigned ready_period = 3;
  always @(negedge clk) begin
    ready_count++;
    if (ready_count % 97 == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_period = $urandom_range(2, 5);
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_PERIODIC: out_ready <= (ready_count % ready_period) != 0;
      READY_RANDOM: out_ready <= $urandom_range(0, 3) != 0;
      default: out_ready <= (ready_count % 16) >= 8;
    endcase
  end

  // Check every result taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(hit, way, replaced_valid);
  end

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    in_valid <= 1'b1;
    address  <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(addr);
  endtask

  task automatic idle_input(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop the request, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  // Reprogram the split and associativity on an idle block
  task automatic configure(input logic [CFG_W-1:0] ways_val, input logic [CFG_W-1:0] off_val,
                           input logic [CFG_W-1:0] idx_val);
    wait_idle();
    write_register(CFG_UNUSED, CFG_W'($urandom_range(0, 15)));
    write_register(CFG_WAYS_IN_USE, ways_val);
    write_register(CFG_OFFSET_BITS, off_val);
    write_register(CFG_INDEX_BITS, idx_val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a small pool of tags over a few sets, so hits and evictions are common
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned off, idx, row_max, row, tag;
    logic [ADDR_W-1:0] low;
    if ($urandom_range(0, 4) == 0) return $urandom();
    off = sb.eff_offset();
    idx = sb.eff_index();
    row_max = ((1 << idx) - 1 < 3) ? (1 << idx) - 1 : 3;
    row = $urandom_range(0, row_max);
    tag = $urandom_range(0, sb.eff_ways() + 2);
    low = $urandom() & ((32'd1 << off) - 1);
    return (ADDR_W'(tag) << (off + idx)) | (ADDR_W'(row) << off) | low;
  endfunction

  initial begin
    int unsigned burst_left;
    bit bursty;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one set, three ways: fill, hit inside a block, evict the oldest line
    configure(4'd3, 4'd4, 4'd0);
    send_address(32'h0000_0000);
    send_address(32'h0000_0008);
    send_address(32'h0000_0010);
    send_address(32'h0000_0020);
    send_address(32'h0000_0010);
    send_address(32'h0000_0030);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFF0);
    // shrink then regrow the ways so ranks tie
    configure(4'd2, 4'd4, 4'd0);
    send_address(32'h0000_0040);
    send_address(32'h0000_0050);
    send_address(32'h0000_0000);
    configure(4'd3, 4'd4, 4'd0);
    send_address(32'h0000_0060);
    send_address(32'h0000_0070);
    send_address(32'h0000_0080);
    // same tag in two ways: fill with two ways, refill with one, search all
    configure(4'd2, 4'd4, 4'd1);
    send_address(32'h0000_0030);
    send_address(32'h0000_0050);
    configure(4'd0, 4'd4, 4'd1);
    send_address(32'h0000_0050);
    configure(4'd15, 4'd4, 4'd1);
    send_address(32'h0000_0050);
    // oversized offset and index saturate
    configure(4'd8, 4'd15, 4'd15);
    send_address(32'h0000_0000);
    send_address(32'h0000_1000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0FFF);
    send_address(32'h0010_0000);

    // random phases: extremes first, then arbitrary settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(4'd8, 4'd0, 4'd0);
        1: configure(4'd1, 4'd12, 4'd8);
        2: configure(WAYS_IN_USE_RST, OFFSET_BITS_RST, INDEX_BITS_RST);
        3: configure(4'd0, 4'd15, 4'd15);
        default: configure(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                           CFG_W'($urandom_range(0, 15)));
      endcase
      bursty = (p % 3) != 2;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (bursty && burst_left == 0) begin
          idle_input($urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        send_address(pick_address());
        if (burst_left != 0) burst_left--;
      end
    end

    wait_idle();
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[set_assoc_lru_cache_lookup_top.f]
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_cfg.sv
rtl/salc_way_logic.sv
rtl/set_assoc_lru_cache_lookup_top.sv
dv/tb_top.sv
